// ----- sv/sofs_pkg.sv -----
// Package with the types, codes and reset constants of the seat occupancy flush sequencer.
package sofs_pkg;

    localparam int OCC_W   = 16;
    localparam int TIMER_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 8;

    localparam logic [OCC_W-1:0]   OCCUPIED_TICKS_RST = 16'd150;
    localparam logic [OCC_W-1:0]   VACATED_TICKS_RST  = 16'd80;
    localparam logic [TIMER_W-1:0] FIRST_ON_TICKS_RST = 8'd16;
    localparam logic [TIMER_W-1:0] PAUSE_TICKS_RST    = 8'd60;
    localparam logic [TIMER_W-1:0] EXTRA_ON_TICKS_RST = 8'd2;

    typedef enum logic [IDX_W-1:0] {
        REG_OCCUPIED_TICKS = 3'd0,
        REG_VACATED_TICKS  = 3'd1,
        REG_FIRST_ON_TICKS = 3'd2,
        REG_PAUSE_TICKS    = 3'd3,
        REG_EXTRA_ON_TICKS = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_ON    = 2'd1,
        PH_PAUSE = 2'd2,
        PH_EXTRA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [TIMER_W-1:0] extra_on_ticks;
        logic [TIMER_W-1:0] pause_ticks;
        logic [TIMER_W-1:0] first_on_ticks;
        logic [OCC_W-1:0]   vacated_ticks;
        logic [OCC_W-1:0]   occupied_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] manual_cmd;
        logic [1:0] start_cmd;
        logic       factory_test_remote;
        logic       factory_test_local;
        logic       seat_occupied;
        logic       power_on;
    } t_tick;

    typedef struct packed {
        logic               start_flag;
        logic               armed_flag;
        logic [OCC_W-1:0]   occupied_count;
        logic [OCC_W-1:0]   vacated_count;
        t_phase             phase;
        logic [TIMER_W-1:0] phase_timer;
        logic               manual_flag;
        logic               valve;
    } t_state;

endpackage

// ----- sv/seat_occupancy_flush_sequencer_core.sv -----
// Top level of the seat occupancy flush sequencer: input register, tick logic, result register.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0]: power_on, seat_occupied, factory_test_local,
//                       factory_test_remote, start_cmd[1:0], manual_cmd[1:0]
//  m_axis    out        tdata[7:0]: valve_on, start_flag, manual_flag, phase[1:0], zero pad
//  i_cfg     in         write enable, 3-bit register index, 16-bit data
//
// One item per cycle is sustained unless the output stalls; each result is registered.
// The state registers update in the cycle an item moves from the input register to the
// result register, so consecutive items chain without a gap.
// Reset is synchronous and clears state, flags and configuration to their defaults.
// A stall at the output holds the result; the input register still takes one more item.
module seat_occupancy_flush_sequencer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Bits from 0: power_on, seat_occupied, factory_test_local, factory_test_remote,
    // start_cmd[1:0], manual_cmd[1:0].
    input  logic [sofs_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Bits from 0: valve_on, start_flag, manual_flag, phase[1:0], three zero bits.
    output logic [sofs_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                         i_cfg_we,
    input  logic [sofs_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [sofs_pkg::CFG_W-1:0]   i_cfg_data
);
    import sofs_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_tick  r_tick;
    logic   r_in_valid;
    logic   r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic   w_advance;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    sofs_step u_step (
        .i_cfg   (r_cfg),
        .i_tick  (r_tick),
        .i_state (r_state),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.occupied_ticks <= OCCUPIED_TICKS_RST;
            r_cfg.vacated_ticks  <= VACATED_TICKS_RST;
            r_cfg.first_on_ticks <= FIRST_ON_TICKS_RST;
            r_cfg.pause_ticks    <= PAUSE_TICKS_RST;
            r_cfg.extra_on_ticks <= EXTRA_ON_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_OCCUPIED_TICKS: r_cfg.occupied_ticks <= i_cfg_data;
                REG_VACATED_TICKS:  r_cfg.vacated_ticks  <= i_cfg_data;
                REG_FIRST_ON_TICKS: r_cfg.first_on_ticks <= i_cfg_data[TIMER_W-1:0];
                REG_PAUSE_TICKS:    r_cfg.pause_ticks    <= i_cfg_data[TIMER_W-1:0];
                REG_EXTRA_ON_TICKS: r_cfg.extra_on_ticks <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_tick <= t_tick'(s_axis_tdata);
        end
        if (w_advance) begin
            r_out_data <= {3'b000, n_state.phase, n_state.manual_flag,
                           n_state.start_flag, n_state.valve};
        end
    end

endmodule

// ----- sv/sofs_step.sv -----
// Combinational next-state logic for one timer tick of the flush sequencer.
module sofs_step (
    input  sofs_pkg::t_cfg   i_cfg,
    input  sofs_pkg::t_tick  i_tick,
    input  sofs_pkg::t_state i_state,
    output sofs_pkg::t_state o_state
);
    import sofs_pkg::*;

    t_state n;

    always_comb begin
        n = i_state;

        if (i_tick.start_cmd == CMD_SET) begin
            n.start_flag = 1'b1;
        end else if (i_tick.start_cmd == CMD_CLEAR) begin
            n.start_flag = 1'b0;
        end
        if (i_tick.manual_cmd == CMD_SET) begin
            n.manual_flag = 1'b1;
        end else if (i_tick.manual_cmd == CMD_CLEAR) begin
            n.manual_flag = 1'b0;
        end

        if (i_tick.factory_test_local || i_tick.factory_test_remote) begin
            n.valve = 1'b1;
        end else begin
            // Arming and vacancy detection.
            if (!i_tick.power_on) begin
                n.start_flag     = 1'b0;
                n.armed_flag     = 1'b0;
                n.occupied_count = '0;
                n.vacated_count  = '0;
            end else if (n.manual_flag) begin
                n.start_flag     = 1'b1;
                n.armed_flag     = 1'b0;
                n.occupied_count = '0;
                n.vacated_count  = '0;
            end else if (i_tick.seat_occupied) begin
                n.vacated_count = '0;
                if (n.occupied_count < i_cfg.occupied_ticks) begin
                    n.occupied_count = OCC_W'(n.occupied_count + 1'b1);
                end else begin
                    n.armed_flag = 1'b1;
                end
            end else begin
                n.occupied_count = '0;
                if (n.armed_flag) begin
                    if (n.vacated_count < i_cfg.vacated_ticks) begin
                        n.vacated_count = OCC_W'(n.vacated_count + 1'b1);
                    end else begin
                        n.start_flag = 1'b1;
                        n.armed_flag = 1'b0;
                    end
                end else begin
                    n.vacated_count = '0;
                end
            end

            // Flush sequence.
            if (!n.start_flag) begin
                n.valve = 1'b0;
                n.phase = PH_INIT;
            end else begin
                case (n.phase)
                    PH_INIT: begin
                        n.valve       = 1'b0;
                        n.phase_timer = '0;
                        n.phase       = PH_ON;
                    end
                    PH_ON: begin
                        if (n.phase_timer < i_cfg.first_on_ticks) begin
                            n.phase_timer = TIMER_W'(n.phase_timer + 1'b1);
                            n.valve       = 1'b1;
                        end else begin
                            n.phase_timer = '0;
                            n.phase       = PH_PAUSE;
                        end
                    end
                    PH_PAUSE: begin
                        if (n.phase_timer < i_cfg.pause_ticks) begin
                            n.phase_timer = TIMER_W'(n.phase_timer + 1'b1);
                            n.valve       = 1'b0;
                        end else begin
                            n.phase_timer = '0;
                            n.phase       = PH_EXTRA;
                        end
                    end
                    default: begin
                        if (n.phase_timer < i_cfg.extra_on_ticks) begin
                            n.phase_timer = TIMER_W'(n.phase_timer + 1'b1);
                            n.valve       = 1'b1;
                        end else begin
                            n.valve       = 1'b0;
                            n.phase_timer = '0;
                            n.phase       = PH_INIT;
                            n.start_flag  = 1'b0;
                            n.manual_flag = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    assign o_state = n;

endmodule

// ----- sv/sofs_checker.sv -----
// Port-level checker for the flush sequencer core and its bind statement.
module sofs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [sofs_pkg::OUT_W-1:0] m_axis_tdata
);
    import sofs_pkg::*;

    // A result left waiting keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // An accepted item is expected at the output once it has passed the input and result registers.
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
        else $error("accepted item produced no result");

    // A ready consumer never holds back the input.
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The pad bits of a result are zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_W-1:5] == '0))
        else $error("nonzero pad bits in result");

endmodule

bind seat_occupancy_flush_sequencer_core sofs_checker u_sofs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
